[src/dra_pkg.sv]
// Shared types, codes and constants for the device range access table.
`timescale 1ns / 1ps
`default_nettype none

package dra_pkg;

   // Default sizing, handed to the top level parameters.
   localparam int TableEntriesDefault = 64;
   localparam int PermBitsDefault     = 8;

   // Field widths of the request word and of a stored rule.
   localparam int FieldW = 32;
   localparam int MajorW = 12;
   localparam int MinorW = 20;
   localparam int PrioW  = 32;
   localparam int StampW = 32;
   localparam int PermW  = 8;

   // Highest minor that a rule range may reach, in the 33-bit width of the sum of two 32-bit fields.
   localparam logic [FieldW:0] MinorLimit = (FieldW + 1)'((1 << MinorW) - 1);

   // Register reset values.
   localparam logic [PermW-1:0] ValidPermMaskReset = 8'd127;
   localparam logic [PermW-1:0] DefaultPermsReset  = 8'd3;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_CHECK  = 2'd0,
      KIND_LOAD   = 2'd1,
      KIND_UNLOAD = 2'd2
   } dra_kind_type;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      STATUS_INVAL = 3'd1,
      STATUS_EXIST = 3'd2,
      STATUS_NOENT = 3'd3,
      STATUS_FULL  = 3'd4
   } dra_status_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_VALID_PERM_MASK = 2'd0,
      CSR_DEFAULT_PERMS   = 2'd1,
      CSR_STRICT_MODE     = 2'd2
   } dra_csr_type;

   // One request as it enters the sequencer.
   typedef struct packed {
      logic [1:0]        kind;
      logic [FieldW-1:0] major;
      logic [FieldW-1:0] minor;
      logic [FieldW-1:0] span;
      logic [PrioW-1:0]  prio;
      logic [PermW-1:0]  perms;
   } dra_cmd_type;

   // Configuration registers as seen by the sequencer.
   typedef struct packed {
      logic [PermW-1:0] valid_perm_mask;
      logic [PermW-1:0] default_perms;
      logic             strict_mode;
   } dra_cfg_type;

   // Stored rule, without its permission bits.
   typedef struct packed {
      logic              valid;
      logic [MajorW-1:0] major;
      logic [MinorW-1:0] base;
      logic [MinorW-1:0] width;
      logic [PrioW-1:0]  prio;
      logic [StampW-1:0] stamp;
   } dra_entry_type;

   // Result of one request.
   typedef struct packed {
      logic           allowed;
      dra_status_type status;
   } dra_result_type;

endpackage

`default_nettype wire

[src/dra_mem.sv]
// Rule memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dra_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/dra_ctrl.sv]
// Sequencer: scans the rule memory once per request, unless rejected up front, and commits any update.
`timescale 1ns / 1ps
`default_nettype none

module dra_ctrl import dra_pkg::*; #(
   parameter int TABLE_ENTRIES = TableEntriesDefault,
   parameter int PERM_BITS     = PermBitsDefault,
   localparam int IdxW    = $clog2(TABLE_ENTRIES),
   localparam int RightsW = (PERM_BITS < PermW) ? PERM_BITS : PermW,
   localparam int WordW   = $bits(dra_entry_type) + RightsW
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dra_cmd_type      req_cmd,
   input  wire dra_cfg_type      cfg,
   input  wire logic             rsp_free,
   output logic                  res_valid,
   output dra_result_type        res,
   output logic                  mem_wr_en,
   output logic      [IdxW-1:0]  mem_wr_addr,
   output logic      [WordW-1:0] mem_wr_data,
   output logic                  mem_rd_en,
   output logic      [IdxW-1:0]  mem_rd_addr,
   input  wire logic [WordW-1:0] mem_rd_data
);

   localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_COMMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [IdxW-1:0]    idx_ff, idx_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [IdxW-1:0]    rd_idx_ff, rd_idx_in;
   dra_cmd_type        cmd_ff, cmd_in;
   logic               early_ff, early_in;
   logic               found_ff, found_in;
   logic [PrioW-1:0]   best_prio_ff, best_prio_in;
   logic [StampW-1:0]  best_stamp_ff, best_stamp_in;
   logic [RightsW-1:0] best_rights_ff, best_rights_in;
   logic               dup_ff, dup_in;
   logic               free_found_ff, free_found_in;
   logic [IdxW-1:0]    free_idx_ff, free_idx_in;
   logic               hit_found_ff, hit_found_in;
   logic [IdxW-1:0]    hit_idx_ff, hit_idx_in;
   logic [StampW-1:0]  stamp_ff, stamp_in;

   dra_entry_type      rd_entry;
   logic [RightsW-1:0] rd_rights;
   logic               key_eq;
   logic               range_hit;
   logic               beats;
   logic               load_bad;
   logic [FieldW:0]    range_end;
   logic [MinorW:0]    entry_end;
   logic [RightsW-1:0] mode;
   logic               commit_wr;
   logic               load_commit;
   dra_entry_type      new_entry;

   assign {rd_rights, rd_entry} = mem_rd_data;
   assign mode = cmd_ff.perms[RightsW-1:0];

   // Load argument validation, done on the incoming word.
   assign range_end = {1'b0, req_cmd.minor} + {1'b0, req_cmd.span};
   assign load_bad  = (req_cmd.major[FieldW-1:MajorW] != '0)
                   || (req_cmd.minor[FieldW-1:MinorW] != '0)
                   || (range_end > MinorLimit)
                   || ((req_cmd.perms[RightsW-1:0]
                        & ~cfg.valid_perm_mask[RightsW-1:0]) != '0);

   // Compare the rule read back against the current request.
   assign key_eq = (cmd_ff.major[FieldW-1:MajorW] == '0)
                && (cmd_ff.minor[FieldW-1:MinorW] == '0)
                && (cmd_ff.span[FieldW-1:MinorW] == '0)
                && (rd_entry.major == cmd_ff.major[MajorW-1:0])
                && (rd_entry.base == cmd_ff.minor[MinorW-1:0])
                && (rd_entry.width == cmd_ff.span[MinorW-1:0]);

   assign entry_end = {1'b0, rd_entry.base} + {1'b0, rd_entry.width};
   assign range_hit = rd_entry.valid
                   && (cmd_ff.major[FieldW-1:MajorW] == '0)
                   && (rd_entry.major == cmd_ff.major[MajorW-1:0])
                   && (cmd_ff.minor[FieldW-1:MinorW] == '0)
                   && (cmd_ff.minor[MinorW-1:0] >= rd_entry.base)
                   && ({1'b0, cmd_ff.minor[MinorW-1:0]} <= entry_end)
                   && (rd_entry.prio != '0);

   // Higher priority wins; on equal priority the newer stamp wins.
   assign beats = !found_ff
               || (rd_entry.prio > best_prio_ff)
               || ((rd_entry.prio == best_prio_ff) && (rd_entry.stamp > best_stamp_ff));

   // Result and write-back decided from the finished scan.
   always_comb begin
      res.allowed = 1'b0;
      res.status  = STATUS_OK;
      commit_wr   = 1'b0;
      mem_wr_addr = hit_idx_ff;
      if (early_ff) begin
         res.status = STATUS_INVAL;
      end else begin
         case (cmd_ff.kind)
            KIND_CHECK: begin
               if (found_ff) begin
                  res.allowed = ((best_rights_ff & mode) == mode);
               end else begin
                  res.allowed = !cfg.strict_mode
                             && ((cfg.default_perms[RightsW-1:0] & mode) == mode);
               end
            end
            KIND_LOAD: begin
               mem_wr_addr = free_idx_ff;
               if (dup_ff) begin
                  res.status = STATUS_EXIST;
               end else if (!free_found_ff) begin
                  res.status = STATUS_FULL;
               end else begin
                  commit_wr = 1'b1;
               end
            end
            KIND_UNLOAD: begin
               if (hit_found_ff) begin
                  commit_wr = 1'b1;
               end else begin
                  res.status = STATUS_NOENT;
               end
            end
            default: begin
               res.status = STATUS_INVAL;
            end
         endcase
      end
      if (state_ff == S_CLEAR) begin
         mem_wr_addr = idx_ff;
      end
   end

   // New rule image; an unload writes the same slot back with valid low.
   always_comb begin
      new_entry.valid = (cmd_ff.kind == KIND_LOAD);
      new_entry.major = cmd_ff.major[MajorW-1:0];
      new_entry.base  = cmd_ff.minor[MinorW-1:0];
      new_entry.width = cmd_ff.span[MinorW-1:0];
      new_entry.prio  = cmd_ff.prio;
      new_entry.stamp = stamp_ff;
   end

   assign load_commit = (state_ff == S_COMMIT) && rsp_free && commit_wr
                     && (cmd_ff.kind == KIND_LOAD);
   assign mem_wr_en   = (state_ff == S_CLEAR)
                     || ((state_ff == S_COMMIT) && rsp_free && commit_wr);
   assign mem_wr_data = (state_ff == S_CLEAR) ? '0 : {mode, new_entry};
   assign mem_rd_en   = (state_ff == S_SCAN);
   assign mem_rd_addr = idx_ff;
   assign req_ready   = (state_ff == S_IDLE);
   assign res_valid   = (state_ff == S_COMMIT);

   // Next state of the sequencer and of the scan accumulators.
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      rd_pend_in     = (state_ff == S_SCAN);
      rd_idx_in      = idx_ff;
      cmd_in         = cmd_ff;
      early_in       = early_ff;
      found_in       = found_ff;
      best_prio_in   = best_prio_ff;
      best_stamp_in  = best_stamp_ff;
      best_rights_in = best_rights_ff;
      dup_in         = dup_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      stamp_in       = load_commit ? stamp_ff + 1'b1 : stamp_ff;

      case (state_ff)
         S_CLEAR: begin
            if (idx_ff == LastIdx) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_cmd;
               idx_in        = '0;
               found_in      = 1'b0;
               dup_in        = 1'b0;
               free_found_in = 1'b0;
               hit_found_in  = 1'b0;
               if (!(req_cmd.kind inside {KIND_CHECK, KIND_LOAD, KIND_UNLOAD})
                   || ((req_cmd.kind == KIND_LOAD) && load_bad)) begin
                  early_in = 1'b1;
                  state_in = S_COMMIT;
               end else begin
                  early_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LastIdx) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Fold in the rule that arrived from the memory this cycle.
      if (rd_pend_ff) begin
         if (range_hit && beats) begin
            found_in       = 1'b1;
            best_prio_in   = rd_entry.prio;
            best_stamp_in  = rd_entry.stamp;
            best_rights_in = rd_rights;
         end
         if (rd_entry.valid && key_eq) begin
            dup_in = 1'b1;
         end
         if (!rd_entry.valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
         if (rd_entry.valid && key_eq && (rd_entry.prio == cmd_ff.prio) && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = rd_idx_ff;
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
         stamp_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         rd_pend_ff <= rd_pend_in;
         stamp_ff   <= stamp_in;
      end
      rd_idx_ff      <= rd_idx_in;
      cmd_ff         <= cmd_in;
      early_ff       <= early_in;
      found_ff       <= found_in;
      best_prio_ff   <= best_prio_in;
      best_stamp_ff  <= best_stamp_in;
      best_rights_ff <= best_rights_in;
      dup_ff         <= dup_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      hit_found_ff   <= hit_found_in;
      hit_idx_ff     <= hit_idx_in;
   end

   // An accepted word always starts a scan or goes straight to its result.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ((state_ff == S_SCAN) || (state_ff == S_COMMIT)))
      else $error("accepted word did not start processing");

   // Read data is only folded in while the scan is running or draining.
   assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> ((state_ff == S_SCAN) || (state_ff == S_DRAIN)))
      else $error("read data pending outside of a scan");

   // Reads and writes of the rule memory never overlap.
   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !mem_rd_en)
      else $error("rule memory read and written in the same cycle");

   // Each stored rule takes the next stamp.
   assert property (@(posedge clock) disable iff (reset)
      load_commit |=> (stamp_ff == $past(stamp_ff) + 32'd1))
      else $error("stamp did not advance on a stored rule");

endmodule

`default_nettype wire

[src/device_range_access_table.sv]
// Top level of the device range access table: ports, configuration and result register.
// The table keeps up to TABLE_ENTRIES device rules in one single-port-write,
// single-port-read memory. Every check, load and unload reads all entries in
// turn, one per cycle, then drains the last read and commits its result before
// the next word is accepted; a load with bad arguments and an unknown kind
// skip the scan and go straight to the commit step. A result waiting on
// rsp_tready holds the next word in its commit step until the output register
// frees. After reset a clearing pass over all TABLE_ENTRIES entries marks every
// entry empty, and req_tready stays low until it ends; configuration writes
// are taken at any time and should be issued only while the table is idle.
`timescale 1ns / 1ps
`default_nettype none

module device_range_access_table import dra_pkg::*; #(
   parameter int TABLE_ENTRIES = TableEntriesDefault,
   parameter int PERM_BITS     = PermBitsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request words.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [31:0] major, [63:32] minor, [95:64] span, [127:96] priority_req, [135:128] perms
   input  wire logic [135:0] req_tdata,
   // [1:0] kind
   input  wire logic [1:0]   req_tuser,
   // Result words.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [0] allowed, [3:1] status, [7:4] zero
   output logic      [7:0]   rsp_tdata,
   // Configuration writes.
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [7:0]   csr_data
);

   localparam int IdxW    = $clog2(TABLE_ENTRIES);
   localparam int RightsW = (PERM_BITS < PermW) ? PERM_BITS : PermW;
   localparam int WordW   = $bits(dra_entry_type) + RightsW;

   dra_cfg_type    cfg_ff, cfg_in;
   logic           rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]     rsp_tdata_ff, rsp_tdata_in;
   dra_cmd_type    req_cmd;
   logic           rsp_free;
   logic           res_valid;
   dra_result_type res;
   logic             mem_wr_en;
   logic [IdxW-1:0]  mem_wr_addr;
   logic [WordW-1:0] mem_wr_data;
   logic             mem_rd_en;
   logic [IdxW-1:0]  mem_rd_addr;
   logic [WordW-1:0] mem_rd_data;

   // Unpack the request word.
   always_comb begin
      req_cmd.kind  = req_tuser;
      req_cmd.major = req_tdata[31:0];
      req_cmd.minor = req_tdata[63:32];
      req_cmd.span  = req_tdata[95:64];
      req_cmd.prio  = req_tdata[127:96];
      req_cmd.perms = req_tdata[135:128];
   end

   // Configuration registers; unknown indexes are dropped.
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VALID_PERM_MASK: cfg_in.valid_perm_mask = csr_data;
            CSR_DEFAULT_PERMS:   cfg_in.default_perms   = csr_data;
            CSR_STRICT_MODE:     cfg_in.strict_mode     = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Output register: takes a new result when empty or being drained.
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      if (res_valid && rsp_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {4'b0000, res.status, res.allowed};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.valid_perm_mask <= ValidPermMaskReset;
         cfg_ff.default_perms   <= DefaultPermsReset;
         cfg_ff.strict_mode     <= 1'b0;
         rsp_tvalid_ff          <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   dra_mem #(
      .DEPTH (TABLE_ENTRIES),
      .WIDTH (WordW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   dra_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .PERM_BITS     (PERM_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_cmd),
      .cfg         (cfg_ff),
      .rsp_free    (rsp_free),
      .res_valid   (res_valid),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire
